FILE: rtl/rvc_pkg.sv
// ----------------------------------------------------------------------------
// rvc_pkg: shared types and constants
// Widths of the radial vignette correction datapath and the record that
// travels down the row of divider cells.
// ----------------------------------------------------------------------------
package rvc_pkg;

	localparam int MAX_DIM = 4096;
	localparam int DIM_W   = 13;	// config width and height
	localparam int POS_W   = 12;	// row and column
	localparam int PIX_W   = 8;
	localparam int K_W     = 16;
	localparam int DEN_W   = 26;	// w^2 + h^2
	localparam int SQ_W    = 26;	// one squared offset
	localparam int NUM_W   = 27;	// sum of squared offsets
	localparam int KN_W    = K_W + NUM_W;
	localparam int PD_W    = PIX_W + DEN_W;
	localparam int GD_W    = 45;	// signed gain denominator
	localparam int D_W     = 42;	// positive gain denominator
	localparam int QW      = 9;	// eight result bits and one overflow bit
	localparam int DW      = D_W + QW - 1;
	localparam int NCELL   = QW;
	localparam int NCH     = 3;

	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_K      = 2'd2;

	localparam logic [DIM_W-1:0] WIDTH_RST  = DIM_W'(640);
	localparam logic [DIM_W-1:0] HEIGHT_RST = DIM_W'(480);
	localparam logic [K_W-1:0]   K_RST      = K_W'(26214);
	localparam logic [DIM_W-1:0] DIM_MAX    = DIM_W'(MAX_DIM);

	typedef struct packed {
		logic                      valid;
		logic                      bad;
		logic [NCH-1:0]            nz;
		logic [DW-1:0]             dsh;
		logic [NCH-1:0][DW-1:0]    rem;
		logic [NCH-1:0][QW-1:0]    quo;
	} cell_t;

endpackage

FILE: rtl/rvc_front.sv
// ----------------------------------------------------------------------------
// rvc_front: radius and gain denominator stages
// Squares the doubled offsets, forms k*num and p*den, then the gain
// denominator that seeds the divider row.
// ----------------------------------------------------------------------------
module rvc_front import rvc_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        valid_s1,
	input  logic [POS_W-1:0]            row_s1,
	input  logic [POS_W-1:0]            col_s1,
	input  logic [NCH-1:0][PIX_W-1:0]   pix_s1,
	input  logic [DIM_W-1:0]            width,
	input  logic [DIM_W-1:0]            height,
	input  logic [K_W-1:0]              strength,
	input  logic [DEN_W-1:0]            den,
	output cell_t                       head
);

	logic signed [14:0] dx, dy;
	logic signed [29:0] dx_prod, dy_prod;
	logic               valid_s2, valid_s3, valid_s4;
	logic [SQ_W-1:0]    dxsq_s2, dysq_s2;
	logic [NCH-1:0][PIX_W-1:0] pix_s2;
	logic [NUM_W-1:0]   num;
	logic [KN_W-1:0]    kn_s3;
	logic [NCH-1:0][PD_W-1:0] pd_s3;
	logic [NCH-1:0]     nz_s3;
	logic signed [GD_W-1:0] gden;
	cell_t              head_s4;

	assign dx = $signed({2'b00, col_s1, 1'b0}) - $signed({2'b00, width});
	assign dy = $signed({2'b00, row_s1, 1'b0}) - $signed({2'b00, height});
	assign dx_prod = dx * dx;
	assign dy_prod = dy * dy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dxsq_s2 <= dx_prod[SQ_W-1:0];
			dysq_s2 <= dy_prod[SQ_W-1:0];
			pix_s2  <= pix_s1;
		end
	end

	assign num = {1'b0, dxsq_s2} + {1'b0, dysq_s2};

	always_ff @(posedge clk) begin
		if (en) begin
			kn_s3 <= strength * num;
			for (int i = 0; i < NCH; i++) begin
				pd_s3[i] <= pix_s2[i] * den;
				nz_s3[i] <= |pix_s2[i];
			end
		end
	end

	// D = den*65536 - k*num, zero or negative only off the frame
	assign gden = $signed({3'b000, den, 16'h0000}) - $signed({2'b00, kn_s3});

	always_ff @(posedge clk) begin
		if (en) begin
			head_s4.valid <= 1'b0;
			head_s4.bad   <= gden[GD_W-1] | (gden == '0);
			head_s4.nz    <= nz_s3;
			head_s4.dsh   <= {gden[D_W-1:0], {(QW-1){1'b0}}};
			for (int i = 0; i < NCH; i++) begin
				head_s4.rem[i] <= {pd_s3[i], 16'h0000};
				head_s4.quo[i] <= '0;
			end
		end
	end

	always_comb begin
		head = head_s4;
		head.valid = valid_s4;
	end

endmodule

FILE: rtl/rvc_div_cell.sv
// ----------------------------------------------------------------------------
// rvc_div_cell: one restoring division step
// Decides one quotient bit for each channel and hands the shrunken divisor,
// remainders and partial quotients to the next cell.
// ----------------------------------------------------------------------------
module rvc_div_cell import rvc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  cell_t d,
	output cell_t q
);

	cell_t          nxt;
	cell_t          data_q;
	logic           valid_q;
	logic [NCH-1:0] ge;

	always_comb begin
		nxt = d;
		nxt.dsh = d.dsh >> 1;
		for (int i = 0; i < NCH; i++) begin
			ge[i] = d.rem[i] >= d.dsh;
			nxt.rem[i] = ge[i] ? d.rem[i] - d.dsh : d.rem[i];
			nxt.quo[i] = {d.quo[i][QW-2:0], ge[i]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= d.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_q <= nxt;
		end
	end

	always_comb begin
		q = data_q;
		q.valid = valid_q;
	end

endmodule

FILE: rtl/radial_vignette_correction.sv
// ----------------------------------------------------------------------------
// radial_vignette_correction: radial gain correction of BGR pixels
// Brightens each pixel by 1/(1 - k*dn^2) with an exact truncated quotient.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_stall carries pixel_row, pixel_col and the
//   three samples; a transaction happens when in_valid is high and in_stall
//   low. Output channel out_valid/out_stall carries the corrected samples.
//   Configuration writes use cfg_valid/cfg_ready with cfg_index and
//   cfg_data; cfg_ready is always high, writes must be issued only while idle.
//   out_valid follows the input transaction through the input
//   register, three arithmetic stages, nine divider cells (one quotient bit
//   each, the first flags overflow) and the output register.
//   Throughput is one pixel per cycle while the pipeline is not frozen; the divider row is fully pipelined.
//   While out_stall holds a valid result the whole pipeline freezes and a
//   one-entry skid buffer takes the pixel already offered; in_stall rises
//   only while that buffer is full.
//   Reset empties the pipeline and skid buffer and loads width 640,
//   height 480 and k = 26214.
// ----------------------------------------------------------------------------
module radial_vignette_correction import rvc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [POS_W-1:0]   pixel_row,
	input  logic [POS_W-1:0]   pixel_col,
	input  logic [PIX_W-1:0]   blue_in,
	input  logic [PIX_W-1:0]   green_in,
	input  logic [PIX_W-1:0]   red_in,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [PIX_W-1:0]   blue_out,
	output logic [PIX_W-1:0]   green_out,
	output logic [PIX_W-1:0]   red_out,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data
);

	logic [DIM_W-1:0] width_q, height_q, cfg_dim;
	logic [K_W-1:0]   strength_q;
	logic [DEN_W-1:0] den_q;
	logic             adv, acc;
	logic             skid_q;
	logic [POS_W-1:0] skid_row_q, skid_col_q;
	logic [NCH-1:0][PIX_W-1:0] skid_pix_q, in_pix;
	logic             valid_s1;
	logic [POS_W-1:0] row_s1, col_s1;
	logic [NCH-1:0][PIX_W-1:0] pix_s1;
	cell_t            chain [NCELL+1];
	logic             out_valid_q;
	logic [NCH-1:0][PIX_W-1:0] res, out_q;

	assign cfg_ready = 1'b1;
	assign cfg_dim = (cfg_data[DIM_W-1:0] > DIM_MAX) ? DIM_MAX : cfg_data[DIM_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q    <= WIDTH_RST;
			height_q   <= HEIGHT_RST;
			strength_q <= K_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_WIDTH:  width_q    <= cfg_dim;
				REG_HEIGHT: height_q   <= cfg_dim;
				REG_K:      strength_q <= cfg_data;
				default:    ;
			endcase
		end
	end

	// frame diagonal term follows the registers, stable while idle
	always_ff @(posedge clk) begin
		den_q <= DEN_W'(width_q * width_q) + DEN_W'(height_q * height_q);
	end

	assign adv      = !out_valid_q || !out_stall;
	assign in_stall = skid_q;
	assign acc      = in_valid && !skid_q;
	assign in_pix   = {red_in, green_in, blue_in};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_q   <= 1'b0;
			valid_s1 <= 1'b0;
		end else if (adv) begin
			skid_q   <= 1'b0;
			valid_s1 <= skid_q || acc;
		end else if (acc) begin
			skid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!adv && acc) begin
			skid_row_q <= pixel_row;
			skid_col_q <= pixel_col;
			skid_pix_q <= in_pix;
		end
		if (adv) begin
			row_s1 <= skid_q ? skid_row_q : pixel_row;
			col_s1 <= skid_q ? skid_col_q : pixel_col;
			pix_s1 <= skid_q ? skid_pix_q : in_pix;
		end
	end

	rvc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.valid_s1 (valid_s1),
		.row_s1   (row_s1),
		.col_s1   (col_s1),
		.pix_s1   (pix_s1),
		.width    (width_q),
		.height   (height_q),
		.strength (strength_q),
		.den      (den_q),
		.head     (chain[0])
	);

	for (genvar c = 0; c < NCELL; c++) begin : g_cell
		rvc_div_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (adv),
			.d      (chain[c]),
			.q      (chain[c+1])
		);
	end

	// off-frame pixels see unbounded gain; top quotient bit means overflow
	always_comb begin
		for (int i = 0; i < NCH; i++) begin
			if (chain[NCELL].bad) begin
				res[i] = chain[NCELL].nz[i] ? 8'hFF : 8'h00;
			end else if (chain[NCELL].quo[i][QW-1]) begin
				res[i] = 8'hFF;
			end else begin
				res[i] = chain[NCELL].quo[i][PIX_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= chain[NCELL].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign blue_out  = out_q[0];
	assign green_out = out_q[1];
	assign red_out   = out_q[2];

`ifndef ASSERT_OFF
	a_width_max: assert property (@(posedge clk) disable iff (!arst_n)
		width_q <= DIM_MAX) else $error("width above limit");
	a_height_max: assert property (@(posedge clk) disable iff (!arst_n)
		height_q <= DIM_MAX) else $error("height above limit");
	a_skid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		skid_q && !adv |=> skid_q) else $error("skid entry lost while frozen");
	a_skid_drain: assert property (@(posedge clk) disable iff (!arst_n)
		skid_q && adv |=> !skid_q && valid_s1) else $error("skid entry not drained");
`endif

endmodule
